>>> rtl/core/bollinger_band_tracker_defines.svh
// ----------------------------------------------------------------------------
// bollinger band tracker assertion macros
// shared concurrent assertion forms, clocked on clk, reset by rst_n
// ----------------------------------------------------------------------------
`ifndef BOLLINGER_BAND_TRACKER_DEFINES_SVH
`define BOLLINGER_BAND_TRACKER_DEFINES_SVH

// same-cycle implication
`define BBT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bbt_pkg.sv
// ----------------------------------------------------------------------------
// bbt_pkg
// shared widths and types of the bollinger band tracker
// ----------------------------------------------------------------------------
package bbt_pkg;

  localparam int SAMPLE_W = 24;
  localparam int BAND_W   = 26;

  // status of the square-root unit
  typedef struct packed {
    logic busy;
    logic done;
  } bbt_sqrt_stat_t;

endpackage

>>> rtl/core/bbt_ram.sv
// ----------------------------------------------------------------------------
// bbt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bbt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bbt_isqrt.sv
// ----------------------------------------------------------------------------
// bbt_isqrt
// floored integer square root, one radix-4 digit per cycle
// ----------------------------------------------------------------------------
module bbt_isqrt
  import bbt_pkg::*;
#(
  parameter int DW = 58
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DW-1:0]       radicand,
  output logic [DW/2-1:0]     root,
  output bbt_sqrt_stat_t      stat
);

  localparam int HW = DW / 2;
  localparam int CW = $clog2(HW + 1);

  logic [DW-1:0]   v_r, v_nxt;
  logic [HW+1:0]   rem_r, rem_nxt;
  logic [HW-1:0]   root_r, root_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [HW+3:0]   rem_sh;
  logic [HW+3:0]   trial;
  logic [HW+3:0]   rem_sub;
  logic            ge;

  // trial subtract of (4*root + 1) from the shifted remainder
  assign rem_sh  = {rem_r, v_r[DW-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_comb begin
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      v_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CW'(HW);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      v_nxt    = v_r << 2;
      rem_nxt  = ge ? rem_sub[HW+1:0] : rem_sh[HW+1:0];
      root_nxt = {root_r[HW-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/core/bollinger_band_tracker.sv
// ----------------------------------------------------------------------------
// bollinger_band_tracker
// moving average, population deviation and 2-sigma bands over a sample ring
// ----------------------------------------------------------------------------
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, in_sample                | sink
//  out     | out_valid, out_ready, out_valid_res,         | source
//          | out_middle_band, out_std_dev, out_upper_band, |
//          | out_lower_band                               |
//
//  one item at a time; while the window is filling an item skips the band math,
//  with a full window the mean, the deviation and the bands are worked out,
//  paced by the square-root unit retiring one radix-4 digit per cycle
//  synchronous active-low reset clears sums, pointer, fill count and control;
//  the ring itself is not cleared, an entry's read data is used only once it holds a sample
//  the output register holds a result until its transfer, and the next input
//  transfer is taken meanwhile; only the final step waits on out_ready
//
`include "bollinger_band_tracker_defines.svh"

module bollinger_band_tracker
  import bbt_pkg::*;
#(
  parameter int WINDOW = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_W-1:0]      in_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_valid_res,
  output logic [SAMPLE_W-1:0]      out_middle_band,
  output logic [SAMPLE_W-1:0]      out_std_dev,
  output logic [BAND_W-1:0]        out_upper_band,
  output logic signed [BAND_W-1:0] out_lower_band
);

  // widths that follow from the window length
  localparam int LG = $clog2(WINDOW);
  localparam int SW = SAMPLE_W + LG;         // running sum, also root width
  localparam int QW = 2 * SAMPLE_W + LG;     // running sum of squares
  localparam int DW = 2 * SW;                // product and radicand
  localparam int AW = $clog2(WINDOW);        // ring address
  localparam int FW = $clog2(WINDOW + 1);    // fill count

  localparam logic [SW-1:0] N_W   = SW'(WINDOW);
  // floor(2^SW / N): x*RECIP >> SW is floor(x/N) or one below it
  localparam logic [SW-1:0] RECIP = SW'((64'd1 << SW) / WINDOW);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_RD    = 11'b000_0000_0010,
    ST_SQN   = 11'b000_0000_0100,
    ST_ACC   = 11'b000_0000_1000,
    ST_SUMSQ = 11'b000_0001_0000,
    ST_DIFF  = 11'b000_0010_0000,
    ST_DQ    = 11'b000_0100_0000,
    ST_DQN   = 11'b000_1000_0000,
    ST_DCOR  = 11'b001_0000_0000,
    ST_SQRT  = 11'b010_0000_0000,
    ST_FIN   = 11'b100_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic [QW-1:0]       sumsq_r, sumsq_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic                div_sel_r, div_sel_nxt;
  logic [SW-1:0]       q0_r, q0_nxt;
  logic [SAMPLE_W-1:0] mid_r, mid_nxt;
  logic [SAMPLE_W-1:0] sd_r, sd_nxt;
  logic [DW-1:0]       p_r;

  logic                out_valid_r, out_valid_nxt;
  logic                out_res_r, out_res_nxt;
  logic [SAMPLE_W-1:0] out_mid_r, out_mid_nxt;
  logic [SAMPLE_W-1:0] out_sd_r, out_sd_nxt;
  logic [BAND_W-1:0]   out_up_r, out_up_nxt;
  logic [BAND_W-1:0]   out_lo_r, out_lo_nxt;

  // shared multiplier operands, product registered every cycle
  logic [SW-1:0]       mul_a, mul_b;

  logic                ram_we;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic                full;
  logic [SAMPLE_W-1:0] old;
  logic [DW-1:0]       nsq;
  logic [DW-1:0]       diff;
  logic                sq_start;
  logic [SW-1:0]       sq_root;
  bbt_sqrt_stat_t      sq_stat;
  logic [SW-1:0]       div_x;
  logic [SW-1:0]       div_r;
  logic [SW-1:0]       div_q;

  // ring of the last WINDOW samples
  bbt_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (sample_r),
    .raddr (wp_r),
    .rdata (ram_rdata)
  );

  bbt_isqrt #(
    .DW (DW)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (diff),
    .root     (sq_root),
    .stat     (sq_stat)
  );

  // the oldest sample leaves the sums only once the window is full
  assign full = fill_r == FW'(WINDOW);
  assign old  = full ? ram_rdata : '0;

  // N*sumsq - sum^2, exact modulo 2^DW
  assign nsq  = DW'(sumsq_r) * DW'(N_W);
  assign diff = nsq - p_r;

  // reciprocal division correction: remainder below 2N, one compare
  assign div_x = div_sel_r ? sq_root : sum_r;
  assign div_r = div_x - p_r[SW-1:0];
  assign div_q = q0_r + SW'(div_r >= N_W);

  assign in_ready = state_r == ST_IDLE;

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    res_ok_nxt    = res_ok_r;
    div_sel_nxt   = div_sel_r;
    q0_nxt        = q0_r;
    mid_nxt       = mid_r;
    sd_nxt        = sd_r;
    mul_a         = '0;
    mul_b         = '0;
    ram_we        = 1'b0;
    sq_start      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    out_mid_nxt   = out_mid_r;
    out_sd_nxt    = out_sd_r;
    out_up_nxt    = out_up_r;
    out_lo_nxt    = out_lo_r;

    case (state_r)
      ST_IDLE: begin
        // ring read of the slot about to be replaced starts here
        if (in_valid) begin
          sample_nxt = in_sample;
          state_nxt  = ST_RD;
        end
      end
      ST_RD: begin
        mul_a     = SW'(old);
        mul_b     = SW'(old);
        ram_we    = 1'b1;
        sum_nxt   = sum_r - SW'(old) + SW'(sample_r);
        state_nxt = ST_SQN;
      end
      ST_SQN: begin
        sumsq_nxt = sumsq_r - p_r[QW-1:0];
        mul_a     = SW'(sample_r);
        mul_b     = SW'(sample_r);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        sumsq_nxt  = sumsq_r + p_r[QW-1:0];
        wp_nxt     = (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + AW'(1);
        if (!full) begin
          fill_nxt = fill_r + FW'(1);
        end
        // full after this sample: either already full or one short
        res_ok_nxt = full || (fill_r == FW'(WINDOW - 1));
        state_nxt  = (full || (fill_r == FW'(WINDOW - 1))) ? ST_SUMSQ : ST_FIN;
      end
      ST_SUMSQ: begin
        mul_a     = sum_r;
        mul_b     = sum_r;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        // root runs while the mean is divided out
        sq_start    = 1'b1;
        mul_a       = sum_r;
        mul_b       = RECIP;
        div_sel_nxt = 1'b0;
        state_nxt   = ST_DQ;
      end
      ST_DQ: begin
        q0_nxt    = p_r[DW-1:SW];
        state_nxt = ST_DQN;
      end
      ST_DQN: begin
        mul_a     = q0_r;
        mul_b     = N_W;
        state_nxt = ST_DCOR;
      end
      ST_DCOR: begin
        if (div_sel_r) begin
          sd_nxt    = div_q[SAMPLE_W-1:0];
          state_nxt = ST_FIN;
        end else begin
          mid_nxt   = div_q[SAMPLE_W-1:0];
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_stat.done) begin
          mul_a       = sq_root;
          mul_b       = RECIP;
          div_sel_nxt = 1'b1;
          state_nxt   = ST_DQ;
        end
      end
      ST_FIN: begin
        // load the output register once it is free or being drained
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_ok_r;
          if (res_ok_r) begin
            out_mid_nxt = mid_r;
            out_sd_nxt  = sd_r;
            out_up_nxt  = BAND_W'(mid_r) + BAND_W'({sd_r, 1'b0});
            out_lo_nxt  = BAND_W'(mid_r) - BAND_W'({sd_r, 1'b0});
          end else begin
            out_mid_nxt = '0;
            out_sd_nxt  = '0;
            out_up_nxt  = '0;
            out_lo_nxt  = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      sumsq_r     <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      res_ok_r    <= 1'b0;
      div_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      res_ok_r    <= res_ok_nxt;
      div_sel_r   <= div_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r  <= sample_nxt;
    q0_r      <= q0_nxt;
    mid_r     <= mid_nxt;
    sd_r      <= sd_nxt;
    p_r       <= DW'(mul_a) * DW'(mul_b);
    out_res_r <= out_res_nxt;
    out_mid_r <= out_mid_nxt;
    out_sd_r  <= out_sd_nxt;
    out_up_r  <= out_up_nxt;
    out_lo_r  <= out_lo_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = out_res_r;
  assign out_middle_band = out_mid_r;
  assign out_std_dev     = out_sd_r;
  assign out_upper_band  = out_up_r;
  assign out_lower_band  = $signed(out_lo_r);

  // no second transfer while an item is in progress
  `BBT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                  "input taken while an item is in progress")
  `BBT_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= FW'(WINDOW), "fill count past window")
  // the root runs only under the mean division or the wait for it
  `BBT_ASSERT_IMP(a_sqrt_overlap, sq_stat.busy, state_r == ST_DQ || state_r == ST_DQN || state_r == ST_DCOR || state_r == ST_SQRT, "square root busy outside its window")
  `BBT_ASSERT_IMP(a_band_sum, out_valid && out_valid_res, out_upper_band == BAND_W'(out_middle_band) + BAND_W'({out_std_dev, 1'b0}), "upper band not mid plus twice deviation")
  `BBT_ASSERT_IMP(a_fill_zero, out_valid && !out_valid_res, out_middle_band == '0 && out_std_dev == '0 && out_upper_band == '0, "partial window result not cleared")

endmodule

>>> sim/bollinger_band_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bollinger_band_tracker_test
// drives price samples into the band tracker under varying back-pressure and
// checks every band result against a cycle-free model of the sample window
// ----------------------------------------------------------------------------
module bollinger_band_tracker_test;
  import bbt_pkg::*;

  localparam int WINDOW      = 20;
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int SETTLE      = 100;   // quiet cycles after the last result
  localparam int PHASE_ITEMS = 200;

  localparam logic [SAMPLE_W-1:0] PRICE_MAX = '1;

  // shapes of the random price streams
  typedef enum int {
    PAT_NOISE,
    PAT_FLAT,
    PAT_SWING,
    PAT_DRIFT,
    PAT_ONE_BIT
  } price_pattern_t;

  typedef struct packed {
    logic                valid_res;
    logic [SAMPLE_W-1:0] middle_band;
    logic [SAMPLE_W-1:0] std_dev;
    logic [BAND_W-1:0]   upper_band;
    logic [BAND_W-1:0]   lower_band;
  } band_result_t;

  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [SAMPLE_W-1:0]      in_sample = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_valid_res;
  logic [SAMPLE_W-1:0]      out_middle_band;
  logic [SAMPLE_W-1:0]      out_std_dev;
  logic [BAND_W-1:0]        out_upper_band;
  logic signed [BAND_W-1:0] out_lower_band;

  // samples waiting to be offered, bands waiting to come out
  logic [SAMPLE_W-1:0] pending_samples[$];
  band_result_t        band_queue[$];

  // idle knobs, percent of cycles
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  int mismatch_count = 0;
  int stall_cycles   = 0;

  // model copy of the window
  logic [SAMPLE_W-1:0] price_ring [WINDOW];
  logic [63:0]         price_sum   = '0;
  logic [63:0]         price_sumsq = '0;
  int                  ring_wr     = 0;
  int                  ring_fill   = 0;

  bollinger_band_tracker #(
    .WINDOW(WINDOW)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_valid_res  (out_valid_res),
    .out_middle_band(out_middle_band),
    .out_std_dev    (out_std_dev),
    .out_upper_band (out_upper_band),
    .out_lower_band (out_lower_band)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floored integer square root, one radix-4 digit per pass
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] probe;
    logic [63:0] rem;
    root  = '0;
    probe = 64'd1 << 62;
    rem   = v;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // push one sample through the model window and queue the band it yields
  task automatic advance_window(input logic [SAMPLE_W-1:0] s);
    logic [63:0]  old;
    logic [63:0]  spread;
    logic [63:0]  mid;
    logic [63:0]  sd;
    band_result_t r;
    // the oldest sample leaves the sums only once the window is full
    if (ring_fill == WINDOW) begin
      old         = price_ring[ring_wr];
      price_sum   = price_sum - old;
      price_sumsq = price_sumsq - old * old;
    end
    price_ring[ring_wr] = s;
    price_sum   = price_sum + 64'(s);
    price_sumsq = price_sumsq + 64'(s) * 64'(s);
    ring_wr     = (ring_wr == WINDOW - 1) ? 0 : ring_wr + 1;
    if (ring_fill < WINDOW) ring_fill++;
    r = '0;
    // while filling, the result carries only zeros
    if (ring_fill == WINDOW) begin
      mid    = price_sum / WINDOW;
      spread = WINDOW * price_sumsq - price_sum * price_sum;
      sd     = floor_sqrt(spread) / WINDOW;
      r.valid_res   = 1'b1;
      r.middle_band = mid[SAMPLE_W-1:0];
      r.std_dev     = sd[SAMPLE_W-1:0];
      r.upper_band  = BAND_W'(mid + 2 * sd);
      r.lower_band  = BAND_W'(mid - 2 * sd);  // wraps below zero
    end
    band_queue.insert(band_queue.size(), r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // extremes first: the filling phase, then a window swinging 0 to full scale,
  // which gives the widest deviation and a lower band below zero
  task automatic queue_directed_items();
    for (int i = 0; i < 22; i++) begin
      pending_samples.insert(pending_samples.size(), (i % 2 == 0) ? '0 : PRICE_MAX);
    end
    pending_samples.insert(pending_samples.size(), SAMPLE_W'(24'h800000));
    pending_samples.insert(pending_samples.size(), SAMPLE_W'(24'h000001));
  endtask

  // random runs of price shapes with random content
  task automatic queue_random_items(input int count);
    int                  left;
    int                  run;
    int                  walk;
    price_pattern_t      pattern;
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] s;
    left = count;
    while (left > 0) begin
      pattern = price_pattern_t'($urandom_range(0, 4));
      run     = $urandom_range(1, 30);
      if (run > left) run = left;
      case ($urandom_range(0, 2))
        0:       level = '0;
        1:       level = PRICE_MAX;
        default: level = SAMPLE_W'($urandom());
      endcase
      walk = $urandom_range(0, 24'hFFFFFF);
      for (int i = 0; i < run; i++) begin
        case (pattern)
          PAT_FLAT: s = level;
          PAT_SWING: s = (i % 2 == 0) ? '0 : PRICE_MAX;
          PAT_DRIFT: begin
            walk = walk + int'($urandom_range(0, 1023)) - 512;
            if (walk < 0) walk = 0;
            if (walk > int'(PRICE_MAX)) walk = int'(PRICE_MAX);
            s = SAMPLE_W'(walk);
          end
          PAT_ONE_BIT: begin
            s = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
            if ($urandom_range(0, 1) == 1) s = ~s;
          end
          default: s = SAMPLE_W'($urandom());
        endcase
        pending_samples.insert(pending_samples.size(), s);
      end
      left -= run;
    end
  endtask

  // driver: a new sample goes out only when the slot is free, so valid and
  // payload hold steady until the transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) advance_window(in_sample);  // transfer at this edge
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid  <= 1'b1;
        in_sample <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // monitor: each result transfer is matched against the oldest band
  always @(posedge clk) begin
    band_result_t want;
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (out_valid && out_ready) begin
        if (band_queue.size() == 0) begin
          report_mismatch("result with none expected", 64'(out_middle_band), '0);
        end else begin
          want = band_queue.pop_front();
          if (out_valid_res !== want.valid_res)
            report_mismatch("valid_res", 64'(out_valid_res), 64'(want.valid_res));
          if (out_middle_band !== want.middle_band)
            report_mismatch("middle_band", 64'(out_middle_band), 64'(want.middle_band));
          if (out_std_dev !== want.std_dev)
            report_mismatch("std_dev", 64'(out_std_dev), 64'(want.std_dev));
          if (out_upper_band !== want.upper_band)
            report_mismatch("upper_band", 64'(out_upper_band), 64'(want.upper_band));
          if ($unsigned(out_lower_band) !== want.lower_band)
            report_mismatch("lower_band", 64'($unsigned(out_lower_band)),
                            64'(want.lower_band));
        end
      end
    end
  end

  // watchdog: too long with no transfer on either channel
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // phases: no idling, sender idle, receiver stalling, both; between phases
  // the sender pauses until every band has come out
  initial begin
    int idle_tab  [4];
    int stall_tab [4];
    idle_tab  = '{0, 55, 0, 34};
    stall_tab = '{0, 0, 55, 34};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      sender_idle_pct    <= idle_tab[phase];
      receiver_stall_pct <= stall_tab[phase];
      if (phase == 0) queue_directed_items();
      queue_random_items(PHASE_ITEMS);
      while (pending_samples.size() != 0 || in_valid) @(negedge clk);
      while (band_queue.size() != 0) @(negedge clk);
    end
    // nothing more may come out
    repeat (SETTLE) @(negedge clk);
    if (band_queue.size() != 0)
      report_mismatch("bands left over", 64'(band_queue.size()), '0);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bbt_pkg.sv
rtl/core/bbt_ram.sv
rtl/core/bbt_isqrt.sv
rtl/core/bollinger_band_tracker.sv
sim/bollinger_band_tracker_test.sv
